// File: hw/rtl/blpi_pkg.sv
// ----------------------------------------------------------------------------
// blpi_pkg
// Shared types, codes and helpers for the bounded list with positional insert.
// ----------------------------------------------------------------------------
package blpi_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  // Fixed port widths of the block.
  localparam int OP_W      = 3;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 5;
  localparam int CNT_OUT_W = 5;
  localparam int STATUS_W  = 2;

  // Width of a cell index; covers the largest supported capacity.
  localparam int IDX_W = 8;

  // Number of compare flags summed per cycle during a count.
  localparam int CHUNK_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_BACK  = 3'd1,
    OP_INSERT    = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_READ      = 3'd4,
    OP_COUNT_GT  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_op_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] pos;
  } cmd_t;

  function automatic logic [3:0] popcount8(input logic [CHUNK_W-1:0] bits);
    logic [3:0] sum;
    sum = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      sum = sum + {3'b000, bits[i]};
    end
    return sum;
  endfunction

endpackage

// File: hw/rtl/blpi_cell.sv
// ----------------------------------------------------------------------------
// blpi_cell
// One list slot: holds an entry and its occupied flag, takes data from its
// left or right neighbor on insert or remove, and compares against threshold.
// ----------------------------------------------------------------------------
module blpi_cell #(
  parameter int INDEX      = 0,
  parameter int ELEM_WIDTH = blpi_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  blpi_pkg::cmd_t                cmd,
  input  logic [ELEM_WIDTH-1:0]         ins_value,
  input  logic [blpi_pkg::VALUE_W-1:0]  threshold,
  input  logic [ELEM_WIDTH-1:0]         left_data,
  input  logic                          left_occ,
  input  logic [ELEM_WIDTH-1:0]         right_data,
  input  logic                          right_occ,
  output logic [ELEM_WIDTH-1:0]         data,
  output logic                          occ,
  output logic                          gt
);

  localparam int CMPW = (ELEM_WIDTH > blpi_pkg::VALUE_W) ? ELEM_WIDTH : blpi_pkg::VALUE_W;
  localparam logic [blpi_pkg::IDX_W-1:0] MY_IDX = blpi_pkg::IDX_W'(INDEX);

  logic [ELEM_WIDTH-1:0] data_r, data_nxt;
  logic                  occ_r, occ_nxt;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    case (cmd.op)
      blpi_pkg::CMD_INSERT: begin
        if (MY_IDX > cmd.pos) begin
          data_nxt = left_data;
          occ_nxt  = left_occ;
        end else if (MY_IDX == cmd.pos) begin
          data_nxt = ins_value;
          occ_nxt  = 1'b1;
        end
      end
      blpi_pkg::CMD_REMOVE: begin
        data_nxt = right_data;
        occ_nxt  = right_occ;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign occ  = occ_r;
  assign gt   = occ_r && (CMPW'(data_r) > CMPW'(threshold));

endmodule

// File: hw/rtl/blpi_ctrl.sv
// ----------------------------------------------------------------------------
// blpi_ctrl
// Operation decoder: checks bounds, drives the cell command, tracks the length
// and sums the cell compare flags a chunk at a time for the count operation.
// ----------------------------------------------------------------------------
module blpi_ctrl #(
  parameter int CAPACITY = blpi_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [blpi_pkg::OP_W-1:0]       op,
  input  logic [blpi_pkg::POS_W-1:0]      pos,
  input  logic [CAPACITY-1:0]             gt,
  output logic                            busy,
  output blpi_pkg::cmd_t                  cmd,
  output logic [$clog2(CAPACITY+1)-1:0]   len,
  output logic                            out_valid,
  output logic [blpi_pkg::CNT_OUT_W-1:0]  greater_count,
  output logic [blpi_pkg::STATUS_W-1:0]   status
);

  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int NCH  = (CAPACITY + blpi_pkg::CHUNK_W - 1) / blpi_pkg::CHUNK_W;
  localparam int MW   = NCH * blpi_pkg::CHUNK_W;
  localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int CMPW = (LW > blpi_pkg::POS_W) ? LW : blpi_pkg::POS_W;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_COUNT = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic                out_valid_r, out_valid_nxt;
  blpi_pkg::status_t   status_r, status_nxt;
  logic [LW-1:0]       cnt_r, cnt_nxt;
  logic [MW-1:0]       mask_r, mask_nxt;
  logic [CHW-1:0]      chunk_r, chunk_nxt;

  logic full, empty, accept;

  assign full   = (len_r == LW'(CAPACITY));
  assign empty  = (len_r == '0);
  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    mask_nxt      = mask_r;
    chunk_nxt     = chunk_r;
    cmd.op        = blpi_pkg::CMD_HOLD;
    cmd.pos       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt    = blpi_pkg::ST_OK;
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          case (op)
            blpi_pkg::OP_ADD_FRONT: begin
              if (full) begin
                status_nxt = blpi_pkg::ST_FULL;
              end else begin
                cmd.op  = blpi_pkg::CMD_INSERT;
                cmd.pos = '0;
                len_nxt = len_r + LW'(1);
              end
            end
            blpi_pkg::OP_ADD_BACK: begin
              if (full) begin
                status_nxt = blpi_pkg::ST_FULL;
              end else begin
                cmd.op  = blpi_pkg::CMD_INSERT;
                cmd.pos = blpi_pkg::IDX_W'(len_r);
                len_nxt = len_r + LW'(1);
              end
            end
            blpi_pkg::OP_INSERT: begin
              // The range check takes priority over the full check.
              if (CMPW'(pos) > CMPW'(len_r)) begin
                status_nxt = blpi_pkg::ST_RANGE;
              end else if (full) begin
                status_nxt = blpi_pkg::ST_FULL;
              end else begin
                cmd.op  = blpi_pkg::CMD_INSERT;
                cmd.pos = blpi_pkg::IDX_W'(pos);
                len_nxt = len_r + LW'(1);
              end
            end
            blpi_pkg::OP_REMOVE: begin
              if (empty) begin
                status_nxt = blpi_pkg::ST_EMPTY;
              end else begin
                cmd.op  = blpi_pkg::CMD_REMOVE;
                len_nxt = len_r - LW'(1);
              end
            end
            blpi_pkg::OP_READ: begin
              if (empty) begin
                status_nxt = blpi_pkg::ST_EMPTY;
              end
            end
            blpi_pkg::OP_COUNT_GT: begin
              // Freeze the compare flags; the count state sums them a chunk at a time.
              out_valid_nxt = 1'b0;
              state_nxt     = S_COUNT;
              mask_nxt      = MW'(gt);
              chunk_nxt     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_COUNT: begin
        cnt_nxt   = cnt_r + LW'(blpi_pkg::popcount8(mask_r[blpi_pkg::CHUNK_W-1:0]));
        mask_nxt  = mask_r >> blpi_pkg::CHUNK_W;
        chunk_nxt = chunk_r + CHW'(1);
        if (chunk_r == CHW'(NCH - 1)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    cnt_r    <= cnt_nxt;
    mask_r   <= mask_nxt;
    chunk_r  <= chunk_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign len           = len_r;
  assign out_valid     = out_valid_r;
  assign greater_count = blpi_pkg::CNT_OUT_W'(cnt_r);
  assign status        = status_r;

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAPACITY))
    else $error("list length exceeds capacity");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op != blpi_pkg::OP_COUNT_GT) |=> out_valid_r && !busy)
    else $error("single-cycle operation gave no result");

  a_count_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op == blpi_pkg::OP_COUNT_GT) |=> busy && !out_valid_r)
    else $error("count operation did not hold the block busy");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == blpi_pkg::ST_FULL) |-> full)
    else $error("full status reported on a list that is not full");
`endif

endmodule

// File: hw/rtl/bounded_list_with_positional_insert_top.sv
// ----------------------------------------------------------------------------
// bounded_list_with_positional_insert_top
// Ordered list of up to CAPACITY words held in a chain of cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and each item gives
// exactly one result, shown for one cycle with out_valid high; the receiver
// cannot stall it. Add, insert, remove, read and unused codes give their
// result in the cycle after the transfer and busy stays low, so such items
// may follow each other every cycle. A count holds busy high while the
// controller sums the cell compare flags eight per cycle, then gives its
// result. Rejected operations leave the list unchanged and report status.
// ----------------------------------------------------------------------------
module bounded_list_with_positional_insert_top #(
  parameter int CAPACITY   = blpi_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = blpi_pkg::ELEM_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [blpi_pkg::OP_W-1:0]       in_operation,
  input  logic [blpi_pkg::VALUE_W-1:0]    in_value,
  input  logic [blpi_pkg::POS_W-1:0]      in_position,
  input  logic [blpi_pkg::VALUE_W-1:0]    in_threshold,
  output logic                            out_valid,
  output logic [blpi_pkg::VALUE_W-1:0]    out_front_value,
  output logic [blpi_pkg::CNT_OUT_W-1:0]  out_length,
  output logic [blpi_pkg::CNT_OUT_W-1:0]  out_greater_count,
  output logic [blpi_pkg::STATUS_W-1:0]   out_status
);

  localparam int LW = $clog2(CAPACITY + 1);

  blpi_pkg::cmd_t         cmd;
  logic [ELEM_WIDTH-1:0]  ins_value;
  logic [ELEM_WIDTH-1:0]  cell_data [CAPACITY];
  logic [CAPACITY-1:0]    cell_occ;
  logic [CAPACITY-1:0]    cell_gt;
  logic [LW-1:0]          len;

  assign ins_value = ELEM_WIDTH'(in_value);

  blpi_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .op            (in_operation),
    .pos           (in_position),
    .gt            (cell_gt),
    .busy          (busy),
    .cmd           (cmd),
    .len           (len),
    .out_valid     (out_valid),
    .greater_count (out_greater_count),
    .status        (out_status)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_data, right_data;
    logic                  left_occ, right_occ;

    if (i == 0) begin : g_first
      assign left_data = '0;
      assign left_occ  = 1'b0;
    end else begin : g_inner_left
      assign left_data = cell_data[i-1];
      assign left_occ  = cell_occ[i-1];
    end

    // The last cell pulls in an empty slot when the list moves toward the front.
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
      assign right_occ  = 1'b0;
    end else begin : g_inner_right
      assign right_data = cell_data[i+1];
      assign right_occ  = cell_occ[i+1];
    end

    blpi_cell #(
      .INDEX      (i),
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .ins_value  (ins_value),
      .threshold  (in_threshold),
      .left_data  (left_data),
      .left_occ   (left_occ),
      .right_data (right_data),
      .right_occ  (right_occ),
      .data       (cell_data[i]),
      .occ        (cell_occ[i]),
      .gt         (cell_gt[i])
    );
  end

  assign out_front_value = cell_occ[0] ? blpi_pkg::VALUE_W'(cell_data[0]) : '0;
  assign out_length      = blpi_pkg::CNT_OUT_W'(len);

`ifndef NO_ASSERTIONS
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_occ) == int'(len))
    else $error("occupied cells disagree with list length");

  a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_occ >> 1) & ~cell_occ) == '0)
    else $error("occupied cells are not packed at the front");
`endif

endmodule

// File: tb/bounded_list_with_positional_insert_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_list_with_positional_insert_top_tb
// Self-checking bench for the bounded list with positional insert.
// ----------------------------------------------------------------------------
// A short table of directed commands covers the empty, full and out-of-range
// cases, the extreme words and every operation code. A long random phase
// follows, which swings the list between empty and full. A shadow list in the
// bench predicts every result. Each result is compared field by field with
// the oldest prediction. Gaps between commands are drawn at random, with
// stretches of back-to-back transfers.
// ----------------------------------------------------------------------------
module bounded_list_with_positional_insert_top_tb;

  localparam int CAP          = blpi_pkg::CAPACITY_DEF;
  localparam int OP_W         = blpi_pkg::OP_W;
  localparam int VALUE_W      = blpi_pkg::VALUE_W;
  localparam int POS_W        = blpi_pkg::POS_W;
  localparam int CNT_OUT_W    = blpi_pkg::CNT_OUT_W;
  localparam int STATUS_W     = blpi_pkg::STATUS_W;
  localparam int RANDOM_ITEMS = 1320;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int N_ROWS       = 19;

  // Codes that the block treats as no operation.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0]   front;
    logic [CNT_OUT_W-1:0] len;
    logic [CNT_OUT_W-1:0] gt_cnt;
    blpi_pkg::status_t    status;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] thr;
    logic [4:0]         reps;
    logic               typed;
    list_result_t       res;
  } list_cmd_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      in_operation;
  logic [VALUE_W-1:0]   in_value;
  logic [POS_W-1:0]     in_position;
  logic [VALUE_W-1:0]   in_threshold;
  logic                 out_valid;
  logic [VALUE_W-1:0]   out_front_value;
  logic [CNT_OUT_W-1:0] out_length;
  logic [CNT_OUT_W-1:0] out_greater_count;
  logic [STATUS_W-1:0]  out_status;

  // Shadow copy of the list.
  logic [VALUE_W-1:0] shadow_words [CAP];
  int unsigned        shadow_len;

  list_result_t  pending_results [$];
  list_cmd_row_t directed_rows [N_ROWS];

  int  cycle_count;
  int  mismatch_count;
  int  report_count;
  int  transfer_count;
  int  op_hits [8];
  int  status_hits [4];
  int  full_visits;
  int  empty_visits;
  bit  burst_mode;
  bit  fill_phase;

  bounded_list_with_positional_insert_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .in_position      (in_position),
    .in_threshold     (in_threshold),
    .out_valid        (out_valid),
    .out_front_value  (out_front_value),
    .out_length       (out_length),
    .out_greater_count(out_greater_count),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Applies one command to the shadow list and returns the result it gives.
  task automatic list_apply(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] pos, input logic [VALUE_W-1:0] thr,
                            output list_result_t res);
    int unsigned       cnt;
    int unsigned       at;
    bit                do_insert;
    blpi_pkg::status_t st;
    cnt       = 0;
    at        = 0;
    do_insert = 1'b0;
    st        = blpi_pkg::ST_OK;
    case (op)
      blpi_pkg::OP_ADD_FRONT, blpi_pkg::OP_ADD_BACK: begin
        if (shadow_len >= CAP) begin
          st = blpi_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
          at        = (op == blpi_pkg::OP_ADD_FRONT) ? 0 : shadow_len;
        end
      end
      blpi_pkg::OP_INSERT: begin
        // The range check wins over the full check.
        if (pos > shadow_len) begin
          st = blpi_pkg::ST_RANGE;
        end else if (shadow_len >= CAP) begin
          st = blpi_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
          at        = pos;
        end
      end
      blpi_pkg::OP_REMOVE: begin
        if (shadow_len == 0) begin
          st = blpi_pkg::ST_EMPTY;
        end else begin
          for (int i = 1; i < shadow_len; i++) shadow_words[i-1] = shadow_words[i];
          shadow_len--;
        end
      end
      blpi_pkg::OP_READ: begin
        if (shadow_len == 0) st = blpi_pkg::ST_EMPTY;
      end
      blpi_pkg::OP_COUNT_GT: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] > thr) cnt++;
        end
      end
      default: ;
    endcase
    if (do_insert) begin
      for (int i = shadow_len; i > at; i--) shadow_words[i] = shadow_words[i-1];
      shadow_words[at] = value;
      shadow_len++;
    end
    res.front  = (shadow_len != 0) ? shadow_words[0] : '0;
    res.len    = CNT_OUT_W'(shadow_len);
    res.gt_cnt = CNT_OUT_W'(cnt);
    res.status = st;
  endtask

  function automatic list_cmd_row_t mk_row(input logic [OP_W-1:0] op,
                                           input logic [VALUE_W-1:0] value,
                                           input logic [POS_W-1:0] pos,
                                           input logic [VALUE_W-1:0] thr,
                                           input logic [4:0] reps, input logic typed,
                                           input logic [VALUE_W-1:0] front,
                                           input logic [CNT_OUT_W-1:0] len,
                                           input logic [CNT_OUT_W-1:0] gt_cnt,
                                           input blpi_pkg::status_t st);
    list_cmd_row_t r;
    r.op         = op;
    r.value      = value;
    r.pos        = pos;
    r.thr        = thr;
    r.reps       = reps;
    r.typed      = typed;
    r.res.front  = front;
    r.res.len    = len;
    r.res.gt_cnt = gt_cnt;
    r.res.status = st;
    return r;
  endfunction

  // Words drawn from the extremes, from small values and from the list itself,
  // so that equal and neighboring thresholds are exercised.
  function automatic logic [VALUE_W-1:0] pick_word(input bit near);
    int unsigned sel;
    logic [VALUE_W-1:0] w;
    sel = $urandom_range(0, 9);
    case (sel)
      0: w = '0;
      1: w = '1;
      2: w = VALUE_W'($urandom_range(0, 15));
      3, 4: begin
        if (shadow_len != 0) begin
          w = shadow_words[$urandom_range(0, shadow_len - 1)];
          if (near) w = w + VALUE_W'($urandom_range(0, 2)) - 1;
        end else begin
          w = $urandom;
        end
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // One command transfer, followed by its prediction.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos, input logic [VALUE_W-1:0] thr,
                           input logic typed, input list_result_t typed_res);
    int unsigned  gap;
    list_result_t res;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= value;
    in_position  <= pos;
    in_threshold <= thr;
    @(posedge clk);
    while (busy) @(posedge clk);
    list_apply(op, value, pos, thr, res);
    pending_results.push_back(typed ? typed_res : res);
    transfer_count++;
    op_hits[op]++;
    status_hits[res.status]++;
    if (shadow_len == CAP) full_visits++;
    if (shadow_len == 0) empty_visits++;
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("Unexpected result: front %h len %0d count %0d status %0d",
                   out_front_value, out_length, out_greater_count, out_status);
        end
      end else begin
        exp_res = pending_results.pop_front();
        if (out_front_value !== exp_res.front || out_length !== exp_res.len ||
            out_greater_count !== exp_res.gt_cnt || out_status !== exp_res.status) begin
          mismatch_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("Mismatch at cycle %0d: expected front %h len %0d count %0d status %0d,",
                     cycle_count, exp_res.front, exp_res.len, exp_res.gt_cnt, exp_res.status);
            $display("  got front %h len %0d count %0d status %0d",
                     out_front_value, out_length, out_greater_count, out_status);
          end
        end
      end
    end
  end

  initial begin
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] thr;
    int unsigned        r;
    list_cmd_row_t      row;
    list_result_t       no_res;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = '0;
    in_value       = '0;
    in_position    = '0;
    in_threshold   = '0;
    cycle_count    = 0;
    mismatch_count = 0;
    report_count   = 0;
    transfer_count = 0;
    full_visits    = 0;
    empty_visits   = 0;
    burst_mode     = 1'b0;
    fill_phase     = 1'b1;
    shadow_len     = 0;
    no_res         = '0;
    foreach (op_hits[i]) op_hits[i] = 0;
    foreach (status_hits[i]) status_hits[i] = 0;

    // Rows with a typed result are checked against that result; the rest
    // against the shadow list.
    directed_rows[0]  = mk_row(blpi_pkg::OP_READ, '0, 0, '0, 1, 1,
                               '0, 0, 0, blpi_pkg::ST_EMPTY);
    directed_rows[1]  = mk_row(blpi_pkg::OP_REMOVE, '0, 0, '0, 1, 1,
                               '0, 0, 0, blpi_pkg::ST_EMPTY);
    directed_rows[2]  = mk_row(blpi_pkg::OP_COUNT_GT, '0, 0, '0, 1, 1,
                               '0, 0, 0, blpi_pkg::ST_OK);
    directed_rows[3]  = mk_row(blpi_pkg::OP_INSERT, '1, 1, '0, 1, 1,
                               '0, 0, 0, blpi_pkg::ST_RANGE);
    directed_rows[4]  = mk_row(OP_UNUSED_LO, '1, 31, '1, 1, 1,
                               '0, 0, 0, blpi_pkg::ST_OK);
    directed_rows[5]  = mk_row(blpi_pkg::OP_ADD_BACK, '1, 0, '0, 1, 1,
                               '1, 1, 0, blpi_pkg::ST_OK);
    directed_rows[6]  = mk_row(blpi_pkg::OP_ADD_FRONT, '0, 0, '0, 1, 1,
                               '0, 2, 0, blpi_pkg::ST_OK);
    // Insert before the last entry: the word must not be appended.
    directed_rows[7]  = mk_row(blpi_pkg::OP_INSERT, 32'h1234_5678, 1, '0, 1, 0,
                               '0, 0, 0, blpi_pkg::ST_OK);
    // Position equal to the length appends.
    directed_rows[8]  = mk_row(blpi_pkg::OP_INSERT, 32'hA5A5_A5A5, 3, '0, 1, 0,
                               '0, 0, 0, blpi_pkg::ST_OK);
    directed_rows[9]  = mk_row(blpi_pkg::OP_INSERT, '1, 31, '0, 1, 1,
                               '0, 4, 0, blpi_pkg::ST_RANGE);
    directed_rows[10] = mk_row(blpi_pkg::OP_COUNT_GT, '0, 0, '0, 1, 0,
                               '0, 0, 0, blpi_pkg::ST_OK);
    directed_rows[11] = mk_row(blpi_pkg::OP_COUNT_GT, '0, 0, 32'hFFFF_FFFE, 1, 0,
                               '0, 0, 0, blpi_pkg::ST_OK);
    directed_rows[12] = mk_row(OP_UNUSED_HI, '0, 0, '0, 1, 0,
                               '0, 0, 0, blpi_pkg::ST_OK);
    directed_rows[13] = mk_row(blpi_pkg::OP_ADD_BACK, 32'h8000_0000, 0, '0, 12, 0,
                               '0, 0, 0, blpi_pkg::ST_OK);
    directed_rows[14] = mk_row(blpi_pkg::OP_ADD_FRONT, '1, 0, '0, 1, 1,
                               '0, 16, 0, blpi_pkg::ST_FULL);
    directed_rows[15] = mk_row(blpi_pkg::OP_INSERT, '1, 16, '0, 1, 1,
                               '0, 16, 0, blpi_pkg::ST_FULL);
    directed_rows[16] = mk_row(blpi_pkg::OP_INSERT, '1, 17, '0, 1, 1,
                               '0, 16, 0, blpi_pkg::ST_RANGE);
    directed_rows[17] = mk_row(blpi_pkg::OP_COUNT_GT, '0, 0, '0, 1, 0,
                               '0, 0, 0, blpi_pkg::ST_OK);
    directed_rows[18] = mk_row(blpi_pkg::OP_REMOVE, '0, 0, '0, 1, 0,
                               '0, 0, 0, blpi_pkg::ST_OK);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      row = directed_rows[i];
      for (int k = 0; k < row.reps; k++) begin
        send_item(row.op, row.value + VALUE_W'(k), row.pos, row.thr, row.typed, row.res);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      // Let the whole pipeline run dry once in the middle of the random phase.
      if (n == RANDOM_ITEMS / 2) wait_all_results();
      if (shadow_len == CAP) fill_phase = 1'b0;
      else if (shadow_len == 0) fill_phase = 1'b1;
      else if ($urandom_range(0, 49) == 0) fill_phase = ~fill_phase;

      r = $urandom_range(0, 99);
      if (fill_phase) begin
        if (r < 25) op = blpi_pkg::OP_ADD_FRONT;
        else if (r < 50) op = blpi_pkg::OP_ADD_BACK;
        else if (r < 75) op = blpi_pkg::OP_INSERT;
        else if (r < 83) op = blpi_pkg::OP_REMOVE;
        else if (r < 89) op = blpi_pkg::OP_READ;
        else if (r < 97) op = blpi_pkg::OP_COUNT_GT;
        else op = (r == 97) ? OP_UNUSED_LO : OP_UNUSED_HI;
      end else begin
        if (r < 10) op = blpi_pkg::OP_ADD_FRONT;
        else if (r < 20) op = blpi_pkg::OP_ADD_BACK;
        else if (r < 30) op = blpi_pkg::OP_INSERT;
        else if (r < 65) op = blpi_pkg::OP_REMOVE;
        else if (r < 75) op = blpi_pkg::OP_READ;
        else if (r < 95) op = blpi_pkg::OP_COUNT_GT;
        else op = (r < 97) ? OP_UNUSED_LO : OP_UNUSED_HI;
      end

      r = $urandom_range(0, 9);
      if (r < 8) pos = POS_W'($urandom_range(0, shadow_len));
      else if (r == 8) pos = POS_W'($urandom_range(shadow_len + 1, 31));
      else pos = POS_W'($urandom_range(0, 31));

      value = pick_word(1'b0);
      thr   = pick_word(1'b1);
      send_item(op, value, pos, thr, 1'b0, no_res);
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count = mismatch_count + pending_results.size();

    $display("Run covered %0d transfers: adds %0d/%0d, inserts %0d, removes %0d, reads %0d,",
             transfer_count, op_hits[blpi_pkg::OP_ADD_FRONT], op_hits[blpi_pkg::OP_ADD_BACK],
             op_hits[blpi_pkg::OP_INSERT], op_hits[blpi_pkg::OP_REMOVE],
             op_hits[blpi_pkg::OP_READ]);
    $display("  counts %0d, unused codes %0d; rejected full %0d, empty %0d, range %0d; %s %0d",
             op_hits[blpi_pkg::OP_COUNT_GT], op_hits[OP_UNUSED_LO] + op_hits[OP_UNUSED_HI],
             status_hits[blpi_pkg::ST_FULL], status_hits[blpi_pkg::ST_EMPTY],
             status_hits[blpi_pkg::ST_RANGE], "list full after transfer:", full_visits);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
